/* hdl/qpo_pkg.sv */
`timescale 1ns / 1ps
// package for the quota patch-to-owner assigner
// types, widths, codes and enums used by every file of the block but qpo_ram; no dependencies

package qpo_pkg;

   localparam int MAX_PROCS  = 256;
   localparam int PROC_AW    = $clog2(MAX_PROCS);
   localparam int PROC_CNT_W = $clog2(MAX_PROCS + 1);

   localparam int CELL_W     = 16;
   localparam int GRID_W     = 9;
   localparam int PTOT_W     = 9;
   localparam int PATCH_W    = 16;
   localparam int COORD_W    = 16;
   localparam int STOP_W     = 17;
   localparam int OWNER_W    = 8;
   localparam int SHARE_W    = 9;
   localparam int CNT_W      = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int QUOT_W     = 17;
   localparam int SPAN_W     = QUOT_W + 1;
   localparam int MUL_W      = 18;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ADDR_W     = PROD_W + 1;
   localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);

   localparam logic [SHARE_W-1:0] SHARE_MAX = '1;
   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELL_X      = 3'd0,
      CSR_CELL_Y      = 3'd1,
      CSR_CELL_Z      = 3'd2,
      CSR_GRID_WIDTH  = 3'd3,
      CSR_GRID_HEIGHT = 3'd4,
      CSR_PROC_TOTAL  = 3'd5,
      CSR_PATCH_TOTAL = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_MUL,
      S_PREP,
      S_WZ,
      S_WY,
      S_WX,
      S_UPD_RD,
      S_UPD_WR,
      S_DONE
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_START,
      OP_DIV_WAIT,
      OP_MUL,
      OP_PREP_STEP,
      OP_WALK_INIT,
      OP_Z_ENTER,
      OP_Z_NEXT,
      OP_Y_ENTER,
      OP_Y_NEXT,
      OP_X_NEXT,
      OP_HIT,
      OP_MISS,
      OP_UPD_WR,
      OP_EMIT
   } dp_op_type;

   typedef enum logic [2:0] {
      DIV_XLO,
      DIV_XHI,
      DIV_YLO,
      DIV_YHI,
      DIV_ZLO,
      DIV_ZHI,
      DIV_QUOTA,
      DIV_GAP
   } div_sel_type;

   typedef enum logic [2:0] {
      MUL_PLANE,
      MUL_ZBASE,
      MUL_YBASE,
      MUL_SHARE_XY,
      MUL_SHARE_Z,
      MUL_LIMIT
   } mul_sel_type;

   typedef struct packed {
      dp_op_type   op;
      div_sel_type div_sel;
      mul_sel_type mul_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic prep_done;
      logic z_stop;
      logic y_stop;
      logic x_hit;
      logic x_end;
      logic rsp_free;
   } dp_status_type;

endpackage

/* hdl/qpo_channels.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces: patch request, owner response, register write
// depends on qpo_pkg

interface qpo_req_if import qpo_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] begin_x;
   logic [COORD_W-1:0] begin_y;
   logic [COORD_W-1:0] begin_z;
   logic [STOP_W-1:0]  stop_x;
   logic [STOP_W-1:0]  stop_y;
   logic [STOP_W-1:0]  stop_z;

   modport source(output valid, begin_x, begin_y, begin_z, stop_x, stop_y, stop_z,
                  input ready);
   modport sink(input valid, begin_x, begin_y, begin_z, stop_x, stop_y, stop_z,
                output ready);
endinterface

interface qpo_rsp_if import qpo_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OWNER_W-1:0] owner;
   logic [SHARE_W-1:0] sharer_count;
   logic               used_fallback;
   logic               quota_overrun;

   modport source(output valid, owner, sharer_count, used_fallback, quota_overrun,
                  input ready);
   modport sink(input valid, owner, sharer_count, used_fallback, quota_overrun,
                output ready);
endinterface

interface qpo_csr_if import qpo_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

/* hdl/qpo_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies

module qpo_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/qpo_div.sv */
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
// depends on qpo_pkg

module qpo_div import qpo_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [QUOT_W-1:0] dividend,
   input  logic [CELL_W-1:0] divisor,
   output logic [QUOT_W-1:0] quot,
   output logic [CELL_W-1:0] rem,
   output logic              done
);

   logic                 busy_ff, done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [QUOT_W-1:0]    rem_ff, rem_in;
   logic [QUOT_W-1:0]    quo_ff, quo_in;
   logic [CELL_W-1:0]    dvs_ff;
   logic [QUOT_W-1:0]    shifted;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff[QUOT_W-2:0], quo_ff[QUOT_W-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = ge ? shifted - {1'b0, dvs_ff} : shifted;
      quo_in  = {quo_ff[QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(QUOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quot = quo_ff;
   assign rem  = rem_ff[CELL_W-1:0];
   assign done = done_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (done_ff && dvs_ff != '0) |-> rem_ff < {1'b0, dvs_ff})
      else $error("divider remainder not below divisor");

endmodule

/* hdl/qpo_datapath.sv */
`timescale 1ns / 1ps
// datapath: registers, divider, multiplier, counter and open-flag rams, cell walk, output stage
// depends on qpo_pkg, qpo_div, qpo_ram

module qpo_datapath import qpo_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [COORD_W-1:0]    begin_x,
   input  logic [COORD_W-1:0]    begin_y,
   input  logic [COORD_W-1:0]    begin_z,
   input  logic [STOP_W-1:0]     stop_x,
   input  logic [STOP_W-1:0]     stop_y,
   input  logic [STOP_W-1:0]     stop_z,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [OWNER_W-1:0]    owner,
   output logic [SHARE_W-1:0]    sharer_count,
   output logic                  used_fallback,
   output logic                  quota_overrun
);

   // configuration
   logic [CELL_W-1:0]  cell_x_ff, cell_y_ff, cell_z_ff;
   logic [GRID_W-1:0]  gw_ff, gh_ff;
   logic [PTOT_W-1:0]  pt_ff;
   logic [PATCH_W-1:0] patch_ff;

   logic [CELL_W-1:0]     cx, cy, cz;
   logic [GRID_W-1:0]     gw1, gh1;
   logic [PROC_CNT_W-1:0] t_val;

   // item
   logic [COORD_W-1:0] bx_ff, by_ff, bz_ff;
   logic [STOP_W-1:0]  sx_ff, sy_ff, sz_ff;

   logic [QUOT_W-1:0]  xs_ff, xe_ff, ys_ff, ye_ff, zs_ff, ze_ff;
   logic [PATCH_W-1:0] q_ff;
   logic [PTOT_W-1:0]  rem_ff, gap_ff, lim_ff;
   logic [MUL_W-1:0]   plane_ff;
   logic [ADDR_W-1:0]  zb_ff, ybase_ff, rowoff_ff, proc_ff;
   logic [SHARE_W-1:0] sh_ff;
   logic [QUOT_W-1:0]  z_ff, y_ff, x_ff;

   // quota pass
   logic [PROC_CNT_W-1:0] p_ff, m_ff;
   logic                  s_v_ff, s_x_ff;
   logic [PROC_AW-1:0]    s_p_ff;
   logic [PROC_AW-1:0]    open_raddr;
   logic                  open_rdata;
   logic                  fb_found_ff;
   logic [PROC_AW-1:0]    fb_ff;

   // result
   logic [PROC_AW-1:0] owner_ff;
   logic               fbk_ff, ovr_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OWNER_W-1:0] rsp_owner_ff;
   logic [SHARE_W-1:0] rsp_share_ff;
   logic               rsp_fb_ff, rsp_ovr_ff;

   // counters
   logic [MAX_PROCS-1:0] vbits_ff;
   logic                 rd_valid_ff;
   logic [PROC_AW-1:0]   raddr;
   logic [CNT_W-1:0]     rdata, cnt_cur;

   // arithmetic
   logic [QUOT_W-1:0] div_dividend, div_quot;
   logic [CELL_W-1:0] div_divisor, div_rem;
   logic              div_done;
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic [SHARE_W-1:0] prod_sat;
   logic [SPAN_W-1:0] xspan, yspan, zspan;
   logic [ADDR_W-1:0] lo, t_wide;
   logic              extra;
   logic [CNT_W:0]    quota;
   logic              open_cur;

   function automatic logic [QUOT_W-1:0] last_coord(logic [COORD_W-1:0] b,
                                                    logic [STOP_W-1:0] s);
      logic [QUOT_W-1:0] r;
      if (s <= {1'b0, b}) begin
         r = {1'b0, b};
      end else begin
         r = s - 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      cx = (cell_x_ff == '0) ? CELL_W'(1) : cell_x_ff;
      cy = (cell_y_ff == '0) ? CELL_W'(1) : cell_y_ff;
      cz = (cell_z_ff == '0) ? CELL_W'(1) : cell_z_ff;
      gw1 = (gw_ff == '0) ? GRID_W'(1) : gw_ff;
      gh1 = (gh_ff == '0) ? GRID_W'(1) : gh_ff;
      if (pt_ff == '0) begin
         t_val = PROC_CNT_W'(1);
      end else if (pt_ff > PTOT_W'(MAX_PROCS)) begin
         t_val = PROC_CNT_W'(MAX_PROCS);
      end else begin
         t_val = PROC_CNT_W'(pt_ff);
      end
      t_wide = ADDR_W'(t_val);
   end

   // divider operands
   always_comb begin
      case (cmd.div_sel)
         DIV_XLO: begin div_dividend = {1'b0, bx_ff}; div_divisor = cx; end
         DIV_XHI: begin div_dividend = last_coord(bx_ff, sx_ff); div_divisor = cx; end
         DIV_YLO: begin div_dividend = {1'b0, by_ff}; div_divisor = cy; end
         DIV_YHI: begin div_dividend = last_coord(by_ff, sy_ff); div_divisor = cy; end
         DIV_ZLO: begin div_dividend = {1'b0, bz_ff}; div_divisor = cz; end
         DIV_ZHI: begin div_dividend = last_coord(bz_ff, sz_ff); div_divisor = cz; end
         DIV_QUOTA: begin
            div_dividend = QUOT_W'(patch_ff);
            div_divisor  = CELL_W'(t_val);
         end
         DIV_GAP: begin
            div_dividend = QUOT_W'(t_val);
            div_divisor  = CELL_W'(rem_ff);
         end
         default: begin div_dividend = '0; div_divisor = CELL_W'(1); end
      endcase
   end

   qpo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIV_START),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quot     (div_quot),
      .rem      (div_rem),
      .done     (div_done)
   );

   // shared multiplier operands
   always_comb begin
      xspan = {1'b0, xe_ff} - {1'b0, xs_ff} + 1'b1;
      yspan = {1'b0, ye_ff} - {1'b0, ys_ff} + 1'b1;
      zspan = {1'b0, ze_ff} - {1'b0, zs_ff} + 1'b1;
      case (cmd.mul_sel)
         MUL_PLANE:    begin mul_a = MUL_W'(gw1);   mul_b = MUL_W'(gh1); end
         MUL_ZBASE:    begin mul_a = MUL_W'(zs_ff); mul_b = plane_ff; end
         MUL_YBASE:    begin mul_a = MUL_W'(ys_ff); mul_b = MUL_W'(gw1); end
         MUL_SHARE_XY: begin mul_a = xspan;         mul_b = yspan; end
         MUL_SHARE_Z:  begin mul_a = MUL_W'(sh_ff); mul_b = zspan; end
         MUL_LIMIT:    begin mul_a = MUL_W'(gap_ff); mul_b = MUL_W'(rem_ff); end
         default:      begin mul_a = '0; mul_b = '0; end
      endcase
      prod     = mul_a * mul_b;
      prod_sat = (prod > PROD_W'(SHARE_MAX)) ? SHARE_MAX : prod[SHARE_W-1:0];
   end

   // counter ram and quota test
   assign raddr = (cmd.op == OP_PREP_STEP) ? p_ff[PROC_AW-1:0] : owner_ff;

   qpo_ram #(.WIDTH(CNT_W), .DEPTH(MAX_PROCS)) u_counts (
      .clock (clock),
      .we    (cmd.op == OP_UPD_WR),
      .waddr (owner_ff),
      .wdata ((cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 1'b1),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      cnt_cur  = rd_valid_ff ? rdata : '0;
      extra    = (rem_ff != '0) && (m_ff == '0) && (p_ff < PROC_CNT_W'(lim_ff));
      quota    = {1'b0, q_ff} + (CNT_W + 1)'(s_x_ff);
      open_cur = {1'b0, cnt_cur} < quota;
      lo       = zb_ff + rowoff_ff + ADDR_W'(xs_ff);
   end

   // open flags, read at the address the walk moves to so the flag is ready with it
   always_comb begin
      case (cmd.op)
         OP_Y_ENTER: open_raddr = lo[PROC_AW-1:0];
         OP_X_NEXT:  open_raddr = proc_ff[PROC_AW-1:0] + 1'b1;
         default:    open_raddr = proc_ff[PROC_AW-1:0];
      endcase
   end

   qpo_ram #(.WIDTH(1), .DEPTH(MAX_PROCS)) u_open (
      .clock (clock),
      .we    (s_v_ff),
      .waddr (s_p_ff),
      .wdata (open_cur),
      .raddr (open_raddr),
      .rdata (open_rdata)
   );

   assign status.div_done  = div_done;
   assign status.prep_done = (p_ff == t_val);
   assign status.z_stop    = (z_ff > ze_ff) || (zb_ff >= t_wide);
   assign status.y_stop    = (y_ff > ye_ff) || (lo >= t_wide);
   assign status.x_hit     = open_rdata;
   assign status.x_end     = (x_ff == xe_ff) || ((proc_ff + 1'b1) >= t_wide);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_x_ff    <= CELL_W'(32);
         cell_y_ff    <= CELL_W'(32);
         cell_z_ff    <= CELL_W'(32);
         gw_ff        <= GRID_W'(1);
         gh_ff        <= GRID_W'(1);
         pt_ff        <= PTOT_W'(1);
         patch_ff     <= PATCH_W'(1);
         vbits_ff     <= '0;
         s_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_CELL_X:      cell_x_ff <= csr_data;
               CSR_CELL_Y:      cell_y_ff <= csr_data;
               CSR_CELL_Z:      cell_z_ff <= csr_data;
               CSR_GRID_WIDTH:  gw_ff     <= csr_data[GRID_W-1:0];
               CSR_GRID_HEIGHT: gh_ff     <= csr_data[GRID_W-1:0];
               CSR_PROC_TOTAL:  pt_ff     <= csr_data[PTOT_W-1:0];
               CSR_PATCH_TOTAL: patch_ff  <= csr_data;
               default: ;
            endcase
         end
         if (cmd.op == OP_UPD_WR) begin
            vbits_ff[owner_ff] <= 1'b1;
         end
         s_v_ff       <= (cmd.op == OP_PREP_STEP);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = (cmd.op == OP_EMIT) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // payload registers
   always_ff @(posedge clock) begin
      rd_valid_ff <= vbits_ff[raddr];
      if (s_v_ff) begin
         if (open_cur && !fb_found_ff) begin
            fb_found_ff <= 1'b1;
            fb_ff       <= s_p_ff;
         end
      end
      case (cmd.op)
         OP_LOAD: begin
            bx_ff       <= begin_x;
            by_ff       <= begin_y;
            bz_ff       <= begin_z;
            sx_ff       <= stop_x;
            sy_ff       <= stop_y;
            sz_ff       <= stop_z;
            p_ff        <= '0;
            m_ff        <= '0;
            fb_found_ff <= 1'b0;
         end
         OP_DIV_WAIT: begin
            if (div_done) begin
               case (cmd.div_sel)
                  DIV_XLO: xs_ff <= div_quot;
                  DIV_XHI: xe_ff <= div_quot;
                  DIV_YLO: ys_ff <= div_quot;
                  DIV_YHI: ye_ff <= div_quot;
                  DIV_ZLO: zs_ff <= div_quot;
                  DIV_ZHI: ze_ff <= div_quot;
                  DIV_QUOTA: begin
                     q_ff   <= div_quot[PATCH_W-1:0];
                     rem_ff <= div_rem[PTOT_W-1:0];
                  end
                  DIV_GAP: gap_ff <= div_quot[PTOT_W-1:0];
                  default: ;
               endcase
            end
         end
         OP_MUL: begin
            case (cmd.mul_sel)
               MUL_PLANE:    plane_ff <= prod[MUL_W-1:0];
               MUL_ZBASE:    zb_ff    <= ADDR_W'(prod);
               MUL_YBASE:    ybase_ff <= ADDR_W'(prod);
               MUL_SHARE_XY: sh_ff    <= prod_sat;
               MUL_SHARE_Z:  sh_ff    <= prod_sat;
               MUL_LIMIT:    lim_ff   <= prod[PTOT_W-1:0];
               default: ;
            endcase
         end
         OP_PREP_STEP: begin
            s_p_ff <= p_ff[PROC_AW-1:0];
            s_x_ff <= extra;
            p_ff   <= p_ff + 1'b1;
            m_ff   <= ((m_ff + 1'b1) == PROC_CNT_W'(gap_ff)) ? '0 : m_ff + 1'b1;
         end
         OP_WALK_INIT: z_ff <= zs_ff;
         OP_Z_ENTER: begin
            y_ff      <= ys_ff;
            rowoff_ff <= ybase_ff;
         end
         OP_Z_NEXT: begin
            z_ff  <= z_ff + 1'b1;
            zb_ff <= zb_ff + ADDR_W'(plane_ff);
         end
         OP_Y_ENTER: begin
            proc_ff <= lo;
            x_ff    <= xs_ff;
         end
         OP_Y_NEXT: begin
            y_ff      <= y_ff + 1'b1;
            rowoff_ff <= rowoff_ff + ADDR_W'(gw1);
         end
         OP_X_NEXT: begin
            x_ff    <= x_ff + 1'b1;
            proc_ff <= proc_ff + 1'b1;
         end
         OP_HIT: begin
            owner_ff <= proc_ff[PROC_AW-1:0];
            fbk_ff   <= 1'b0;
            ovr_ff   <= 1'b0;
         end
         OP_MISS: begin
            owner_ff <= fb_found_ff ? fb_ff : '0;
            fbk_ff   <= 1'b1;
            ovr_ff   <= !fb_found_ff;
         end
         OP_EMIT: begin
            rsp_owner_ff <= OWNER_W'(owner_ff);
            rsp_share_ff <= sh_ff;
            rsp_fb_ff    <= fbk_ff;
            rsp_ovr_ff   <= ovr_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign owner         = rsp_owner_ff;
   assign sharer_count  = rsp_share_ff;
   assign used_fallback = rsp_fb_ff;
   assign quota_overrun = rsp_ovr_ff;

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_X_NEXT || cmd.op == OP_HIT || cmd.op == OP_Y_NEXT)
         |-> proc_ff < t_wide)
      else $error("cell walk outside the process range");
   a_count_marked: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_UPD_WR |=> vbits_ff[$past(owner_ff)])
      else $error("written counter not marked valid");
   a_overrun_owner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovr_ff) |-> (rsp_fb_ff && rsp_owner_ff == '0))
      else $error("overrun item without fallback to process zero");
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |=> rsp_valid_ff)
      else $error("emitted item not presented");

endmodule

/* hdl/qpo_controller.sv */
`timescale 1ns / 1ps
// controller state machine sequencing divides, multiplies, quota pass and cell walk
// depends on qpo_pkg

module qpo_controller import qpo_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   div_sel_type   div_sel_ff, div_sel_in;
   mul_sel_type   mul_sel_ff, mul_sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_sel_ff <= DIV_XLO;
         mul_sel_ff <= MUL_PLANE;
      end else begin
         state_ff   <= state_in;
         div_sel_ff <= div_sel_in;
         mul_sel_ff <= mul_sel_in;
      end
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      div_sel_in = div_sel_ff;
      mul_sel_in = mul_sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in   = S_DIV_GO;
               div_sel_in = DIV_XLO;
            end
         end
         S_DIV_GO: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_DIV_GO;
               case (div_sel_ff)
                  DIV_XLO:   div_sel_in = DIV_XHI;
                  DIV_XHI:   div_sel_in = DIV_YLO;
                  DIV_YLO:   div_sel_in = DIV_YHI;
                  DIV_YHI:   div_sel_in = DIV_ZLO;
                  DIV_ZLO:   div_sel_in = DIV_ZHI;
                  DIV_ZHI:   div_sel_in = DIV_QUOTA;
                  DIV_QUOTA: div_sel_in = DIV_GAP;
                  default: begin
                     state_in   = S_MUL;
                     mul_sel_in = MUL_PLANE;
                  end
               endcase
            end
         end
         S_MUL: begin
            case (mul_sel_ff)
               MUL_PLANE:    mul_sel_in = MUL_ZBASE;
               MUL_ZBASE:    mul_sel_in = MUL_YBASE;
               MUL_YBASE:    mul_sel_in = MUL_SHARE_XY;
               MUL_SHARE_XY: mul_sel_in = MUL_SHARE_Z;
               MUL_SHARE_Z:  mul_sel_in = MUL_LIMIT;
               default:      state_in   = S_PREP;
            endcase
         end
         S_PREP: begin
            if (status.prep_done) begin
               state_in = S_WZ;
            end
         end
         S_WZ: state_in = status.z_stop ? S_UPD_RD : S_WY;
         S_WY: state_in = status.y_stop ? S_WZ : S_WX;
         S_WX: begin
            if (status.x_hit) begin
               state_in = S_UPD_RD;
            end else if (status.x_end) begin
               state_in = S_WY;
            end
         end
         S_UPD_RD: state_in = S_UPD_WR;
         S_UPD_WR: state_in = S_DONE;
         S_DONE: begin
            if (status.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.op      = OP_NONE;
      cmd.div_sel = div_sel_ff;
      cmd.mul_sel = mul_sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (!reset) begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.op = OP_LOAD;
               end
            end
         end
         S_DIV_GO:   cmd.op = OP_DIV_START;
         S_DIV_WAIT: cmd.op = OP_DIV_WAIT;
         S_MUL:      cmd.op = OP_MUL;
         S_PREP:     cmd.op = status.prep_done ? OP_WALK_INIT : OP_PREP_STEP;
         S_WZ:       cmd.op = status.z_stop ? OP_MISS : OP_Z_ENTER;
         S_WY:       cmd.op = status.y_stop ? OP_Z_NEXT : OP_Y_ENTER;
         S_WX: begin
            if (status.x_hit) begin
               cmd.op = OP_HIT;
            end else if (status.x_end) begin
               cmd.op = OP_Y_NEXT;
            end else begin
               cmd.op = OP_X_NEXT;
            end
         end
         S_UPD_WR: cmd.op = OP_UPD_WR;
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.op = OP_EMIT;
            end
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DIV_GO && div_sel_ff == DIV_XLO))
      else $error("accepted item did not start the divides");
   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |=> state_ff == S_IDLE)
      else $error("emit did not return to idle");

endmodule

/* hdl/quota_patch_to_owner_assigner_core.sv */
`timescale 1ns / 1ps
// Assigns each patch to one process under per-process quotas. One item is in work at a
// time; the result waits in an output register, so the next item is taken while it is
// unread. An item runs eight divides in the shared 1-bit-per-cycle divider (cell spans,
// quota, remainder spacing), six products in the shared multiplier, a quota pass that
// reads the counter ram once per process, then a walk over z planes, rows and overlapped
// cells below process_total, and last updates the counter and hands over the result.
// Counters start at zero after reset through per-entry valid bits; no clearing pass.
// Depends on qpo_pkg, qpo_channels, qpo_controller and qpo_datapath.

module quota_patch_to_owner_assigner_core import qpo_pkg::*; (
   input logic     clock,
   input logic     reset,
   qpo_req_if.sink   req_ch,
   qpo_rsp_if.source rsp_ch,
   qpo_csr_if.sink   csr_ch
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ch.ready = !reset;

   qpo_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   qpo_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_valid     (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .begin_x       (req_ch.begin_x),
      .begin_y       (req_ch.begin_y),
      .begin_z       (req_ch.begin_z),
      .stop_x        (req_ch.stop_x),
      .stop_y        (req_ch.stop_y),
      .stop_z        (req_ch.stop_z),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .owner         (rsp_ch.owner),
      .sharer_count  (rsp_ch.sharer_count),
      .used_fallback (rsp_ch.used_fallback),
      .quota_overrun (rsp_ch.quota_overrun)
   );

endmodule
